[rtl/rlcd_pkg.sv]
// Package for the letter-count run-length decoder.
// Holds character codes, status codes and the controller/datapath types.
// No dependencies.
`default_nettype none

package rlcd_pkg;

    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] RESET_SYMBOL  = 8'h20;
    localparam int         RADIX         = 10;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_DONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SYM   = 2'd1,
        PH_COUNT = 2'd2,
        PH_ERR   = 2'd3
    } phase_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EMIT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
        logic emit_final;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/rlcd_ctrl.sv]
// Controller for the letter-count run-length decoder.
// Sequences accept and emit phases; depends on rlcd_pkg.
`default_nettype none

module rlcd_ctrl
    import rlcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       res_stall,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        slot_free;

    assign slot_free = !sts.out_full || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_EMIT;
                end
            end
            CS_EMIT:
            begin
                if (slot_free && sts.emit_final)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            CS_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            CS_EMIT:
            begin
                cmd.emit = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // a transfer always leads into the emit phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == CS_EMIT))
        else $error("accepted item did not start emission");

    // never load and emit together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.emit))
        else $error("load and emit in the same cycle");

    // emit only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!sts.out_full || !res_stall))
        else $error("emit into a held output register");

endmodule

`default_nettype wire

[rtl/rlcd_datapath.sv]
// Datapath for the letter-count run-length decoder: decode state, run
// counters and output register. Depends on rlcd_pkg.
`default_nettype none

module rlcd_datapath
    import rlcd_pkg::*;
#(
    parameter int MAX_RUN = 63
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      sts,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       res_stall,
    output logic            res_valid,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic [1:0]      status,
    output logic            out_last
);

    localparam int CW = (MAX_RUN < 2) ? 1 : $clog2(MAX_RUN + 1);
    localparam int PW = CW + 4;

    // decoder state
    phase_t          phase_reg;
    phase_t          phase_next;
    logic [7:0]      held_reg;
    logic [7:0]      held_next;
    logic [CW-1:0]   run_count_reg;
    logic [CW-1:0]   run_count_next;

    // pending runs from the last accepted byte
    logic [7:0]      sym_a_reg;
    logic [7:0]      sym_b_reg;
    logic [CW-1:0]   cnt_a_reg;
    logic [CW-1:0]   cnt_b_reg;
    logic [CW-1:0]   cnt_a_next;
    logic [CW-1:0]   cnt_b_next;
    status_t         stat_hold_reg;

    // output register
    logic            res_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic            out_last_reg;

    // byte decode
    logic            is_digit;
    logic [3:0]      dval;
    logic [PW-1:0]   acc;
    logic [7:0]      sym_a_new;
    logic [CW-1:0]   cnt_a_new;
    logic [CW-1:0]   cnt_b_new;
    status_t         stat_new;
    phase_t          ph_mid;
    logic [7:0]      held_mid;
    logic [CW-1:0]   rc_mid;
    logic            fin;

    assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign dval     = is_digit ? 4'(in_byte - CHAR_ZERO) : 4'd0;
    assign acc      = PW'(run_count_reg) * PW'(RADIX) + PW'(dval);

    always_comb
    begin
        ph_mid    = phase_reg;
        held_mid  = held_reg;
        rc_mid    = run_count_reg;
        sym_a_new = held_reg;
        cnt_a_new = '0;
        case (phase_reg)
            PH_START:
            begin
                if (is_digit)
                begin
                    ph_mid = PH_ERR;
                end
                else
                begin
                    ph_mid   = PH_SYM;
                    held_mid = in_byte;
                end
            end
            PH_SYM:
            begin
                if (is_digit)
                begin
                    if (PW'(dval) > PW'(MAX_RUN))
                    begin
                        ph_mid = PH_ERR;
                    end
                    else
                    begin
                        ph_mid = PH_COUNT;
                        rc_mid = CW'(dval);
                    end
                end
                else if (in_byte == held_reg)
                begin
                    ph_mid = PH_ERR;
                end
                else
                begin
                    cnt_a_new = CW'(1);
                    held_mid  = in_byte;
                end
            end
            PH_COUNT:
            begin
                if (is_digit)
                begin
                    if (acc > PW'(MAX_RUN))
                    begin
                        ph_mid = PH_ERR;
                    end
                    else
                    begin
                        rc_mid = CW'(acc);
                    end
                end
                else
                begin
                    cnt_a_new = run_count_reg;
                    rc_mid    = '0;
                    ph_mid    = PH_SYM;
                    held_mid  = in_byte;
                end
            end
            default:
            begin
                ph_mid = PH_ERR;
            end
        endcase
    end

    // message end: flush the held run, then return to start
    always_comb
    begin
        phase_next     = ph_mid;
        held_next      = held_mid;
        run_count_next = rc_mid;
        cnt_b_new      = '0;
        stat_new       = ST_OK;
        if (in_last)
        begin
            phase_next     = PH_START;
            held_next      = RESET_SYMBOL;
            run_count_next = '0;
            case (ph_mid)
                PH_SYM:
                begin
                    cnt_b_new = CW'(1);
                    stat_new  = ST_DONE;
                end
                PH_COUNT:
                begin
                    cnt_b_new = rc_mid;
                    stat_new  = ST_DONE;
                end
                default:
                begin
                    stat_new = ST_ERR;
                end
            endcase
        end
        else if (ph_mid == PH_ERR)
        begin
            stat_new = ST_ERR;
        end
    end

    // this emission is the item's final result
    assign fin = ((cnt_a_reg == '0) && (cnt_b_reg <= CW'(1)))
              || ((cnt_a_reg == CW'(1)) && (cnt_b_reg == '0));

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (cmd.load)
        begin
            cnt_a_next = cnt_a_new;
            cnt_b_next = cnt_b_new;
        end
        else if (cmd.emit)
        begin
            if (cnt_a_reg != '0)
            begin
                cnt_a_next = cnt_a_reg - CW'(1);
            end
            else if (cnt_b_reg != '0)
            begin
                cnt_b_next = cnt_b_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            held_reg      <= RESET_SYMBOL;
            run_count_reg <= '0;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            if (cmd.load)
            begin
                phase_reg     <= phase_next;
                held_reg      <= held_next;
                run_count_reg <= run_count_next;
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_a_reg     <= sym_a_new;
            sym_b_reg     <= held_mid;
            stat_hold_reg <= stat_new;
        end
        if (cmd.emit)
        begin
            out_last_reg <= fin;
            status_reg   <= fin ? stat_hold_reg : ST_OK;
            if (cnt_a_reg != '0)
            begin
                out_byte_reg  <= sym_a_reg;
                out_valid_reg <= 1'b1;
            end
            else if (cnt_b_reg != '0)
            begin
                out_byte_reg  <= sym_b_reg;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                out_byte_reg  <= 8'h00;
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_full   = res_valid_reg;
    assign sts.emit_final = fin;

    assign res_valid = res_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_last  = out_last_reg;

    // runs drain fully before the next byte is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> ((cnt_a_reg == '0) && (cnt_b_reg == '0)))
        else $error("load while runs still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(run_count_reg) <= CW'(MAX_RUN)) && (cnt_a_reg <= CW'(MAX_RUN))
        && (cnt_b_reg <= CW'(MAX_RUN)))
        else $error("count above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> res_valid_reg)
        else $error("emit did not fill output register");

endmodule

`default_nettype wire

[rtl/rle_letter_count_decoder_core.sv]
// Top level of the letter-count run-length decoder.
// Instantiates rlcd_ctrl and rlcd_datapath; depends on rlcd_pkg.
//
// Decodes text such as "a3bc12" one byte per transfer: a non-digit byte is a
// symbol and an optional decimal count that follows repeats it (no count
// means one copy). Each input transfer produces one or more result
// transfers, one per cycle unless res_stall holds the output register, the
// final one flagged by out_last and carrying the status (error, or done on a
// clean message end); a byte that decodes to nothing yields a single result
// with out_valid low. An item causes n results (n at least one, at most
// MAX_RUN + 1) and in_stall holds off the next item until the last is out,
// paced by the single output register that emits one decoded byte per cycle
// while res_stall does not hold it. Counts above MAX_RUN put the message in
// error until in_last, after which the decoder returns to its start state.
`default_nettype none

module rle_letter_count_decoder_core
    import rlcd_pkg::*;
#(
    parameter int MAX_RUN = 63
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic [1:0]      status,
    output logic            out_last
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    rlcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlcd_datapath #(
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .status    (status),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire
